>>> hdl/rpe_pkg.sv
`timescale 1ns / 1ps

package rpe_pkg;

	localparam int PAIRS_DEF        = 64;
	localparam int POSITION_BITS_DEF = 16;
	localparam int CORDIC_STEPS     = 24;
	localparam int CW               = 34;
	localparam int ZW               = 33;

	localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032874;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_ROTATE = 1'b1;

	typedef struct packed {
		logic               valid;
		logic               op;
		logic [31:0]        freq;
		logic signed [15:0] qe;
		logic signed [15:0] qo;
		logic signed [15:0] ke;
		logic signed [15:0] ko;
	} side_t;

endpackage

>>> hdl/rpe_scale.sv
`timescale 1ns / 1ps

module rpe_scale (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] freq_in,
	output logic [31:0] freq_out
);

	logic [21:0] f22;
	logic [24:0] t;
	logic [46:0] num_s2;
	logic        hi_s2, lo_s2, hi_s3, lo_s3;
	logic [31:0] f_s2, f_s3, small_s2, small_s3;
	logic [47:0] x;
	logic [25:0] v;
	logic [52:0] prod_s3;
	logic [32:0] sum4;

	assign f22  = freq_in[21:0];
	assign t    = 25'(f22) * 25'd7 - 25'(2 ** 21);
	assign sum4 = 33'(freq_in) + 33'd4;
	assign x    = 48'(num_s2) + 48'd6291456;
	assign v    = x[47:22];

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2   <= 47'(f22) * 47'(t);
			hi_s2    <= freq_in > 32'(2 ** 21);
			lo_s2    <= freq_in < 32'(2 ** 19);
			f_s2     <= freq_in;
			small_s2 <= 32'(sum4 >> 3);
			prod_s3  <= 53'(v) * 53'd44739243;
			hi_s3    <= hi_s2;
			lo_s3    <= lo_s2;
			f_s3     <= f_s2;
			small_s3 <= small_s2;
		end
	end

	always_comb begin
		if (hi_s3)
			freq_out = f_s3;
		else if (lo_s3)
			freq_out = small_s3;
		else
			freq_out = 32'(prod_s3[52:27]);
	end

endmodule

>>> hdl/rpe_cordic.sv
`timescale 1ns / 1ps

module rpe_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [31:0]                      angle,
	input  rpe_pkg::side_t                   side_in,
	output logic signed [rpe_pkg::CW-1:0]    co,
	output logic signed [rpe_pkg::CW-1:0]    si,
	output rpe_pkg::side_t                   side_out
);

	localparam int N = rpe_pkg::CORDIC_STEPS;

	logic signed [rpe_pkg::CW-1:0] x_s [N+1];
	logic signed [rpe_pkg::CW-1:0] y_s [N+1];
	logic signed [rpe_pkg::ZW-1:0] z_s [N+1];
	logic [1:0]                    quad_s [N+1];
	rpe_pkg::side_t                side_s [N+1];

	assign x_s[0]    = rpe_pkg::CORDIC_GAIN_INV;
	assign y_s[0]    = '0;
	assign z_s[0]    = $signed({3'b000, angle[29:0]});
	assign quad_s[0] = angle[31:30];
	assign side_s[0] = side_in;

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [rpe_pkg::ZW-1:0] at;
		assign at = $signed({1'b0, rpe_pkg::ATAN_TURNS[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				quad_s[i+1] <= quad_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				side_s[i+1].valid <= 1'b0;
			else if (en)
				side_s[i+1] <= side_s[i];
		end
	end

	assign side_out = side_s[N];

	always_comb begin
		case (quad_s[N])
			2'd0: begin co = x_s[N];  si = y_s[N];  end
			2'd1: begin co = -y_s[N]; si = x_s[N];  end
			2'd2: begin co = -x_s[N]; si = -y_s[N]; end
			default: begin co = y_s[N]; si = -x_s[N]; end
		endcase
	end

endmodule

>>> hdl/rpe_rotate.sv
`timescale 1ns / 1ps

module rpe_rotate (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic signed [rpe_pkg::CW-1:0] co,
	input  logic signed [rpe_pkg::CW-1:0] si,
	input  rpe_pkg::side_t                side_in,
	output logic                          valid_q,
	output logic                          op_q,
	output logic [15:0]                   qe_q,
	output logic [15:0]                   qo_q,
	output logic [15:0]                   ke_q,
	output logic [15:0]                   ko_q,
	output logic [31:0]                   freq_q,
	output logic                          sat_q
);

	logic signed [49:0] p_s [8];
	logic               valid_s, op_s;
	logic [31:0]        freq_s;
	logic signed [50:0] acc [4];
	logic [15:0]        r [4];
	logic [3:0]         clip;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0] <= co * side_in.qe;
			p_s[1] <= si * side_in.qo;
			p_s[2] <= si * side_in.qe;
			p_s[3] <= co * side_in.qo;
			p_s[4] <= co * side_in.ke;
			p_s[5] <= si * side_in.ko;
			p_s[6] <= si * side_in.ke;
			p_s[7] <= co * side_in.ko;
			op_s   <= side_in.op;
			freq_s <= side_in.freq;
		end
	end

	always_comb begin
		logic signed [50:0] rr;
		acc[0] = 51'(p_s[0]) - 51'(p_s[1]);
		acc[1] = 51'(p_s[2]) + 51'(p_s[3]);
		acc[2] = 51'(p_s[4]) - 51'(p_s[5]);
		acc[3] = 51'(p_s[6]) + 51'(p_s[7]);
		for (int k = 0; k < 4; k++) begin
			rr = (acc[k] + 51'sd536870912) >>> 30;
			clip[k] = 1'b0;
			if (rr > 51'sd32767) begin
				r[k] = 16'h7FFF;
				clip[k] = 1'b1;
			end else if (rr < -51'sd32768) begin
				r[k] = 16'h8000;
				clip[k] = 1'b1;
			end else begin
				r[k] = rr[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_q   <= op_s;
			freq_q <= freq_s;
			if (op_s == rpe_pkg::OP_ROTATE) begin
				qe_q  <= r[0];
				qo_q  <= r[1];
				ke_q  <= r[2];
				ko_q  <= r[3];
				sat_q <= |clip;
			end else begin
				qe_q  <= '0;
				qo_q  <= '0;
				ke_q  <= '0;
				ko_q  <= '0;
				sat_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			valid_s <= side_in.valid;
			valid_q <= valid_s;
		end
	end

endmodule

>>> hdl/rotary_position_embedding_core.sv
`timescale 1ns / 1ps

// Rotary position embedding core.
// Slave stream: one request per beat; tuser = operation (0 load, 1 rotate).
//   Load writes a base frequency (optionally band-scaled) into the pair table.
//   Rotate reads the pair's frequency and rotates the query and key pairs.
// Master stream: one result per request, in order.
// cfg_we/cfg_wdata write use_scaling (reset 1); write only while idle.
// Pipeline: 31 register stages, from the input registers to m_tvalid.
// Throughput: one request per cycle when not stalled; the table is a one-port-write,
//   one-port-read synchronous RAM with a registered read, written and
//   read at the same pipeline stage, so no forwarding is needed.
// The CORDIC is a 24-stage pipeline, one stage per iteration.
// Stall: when m_tvalid is high and m_tready low, the whole pipeline holds
//   and s_tready drops; otherwise a request is taken every cycle.
// Reset clears all valid bits and sets use_scaling; table contents are
//   undefined until loaded and need no clearing pass.
module rotary_position_embedding_core #(
	parameter int PAIRS         = rpe_pkg::PAIRS_DEF,
	parameter int POSITION_BITS = rpe_pkg::POSITION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pair_index, base_freq, position, q_even, q_odd, k_even, k_odd
	input  logic [119:0] s_tdata,
	// operation
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// q_even_out, q_odd_out, k_even_out, k_odd_out, stored_freq, saturated
	output logic [103:0] m_tdata
);

	localparam int AW = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam logic [15:0] POS_MASK = (POSITION_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << POSITION_BITS) - 32'd1);

	logic en;
	logic use_scaling_q;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        op_s1, op_s2, op_s3, op_s4;
	logic        in_s1, in_s2, in_s3, in_s4;
	logic [5:0]  pair_s1, pair_s2, pair_s3;
	logic [31:0] base_s1;
	logic [15:0] pos_s1, pos_s2, pos_s3, pos_s4;
	logic [63:0] qk_s1, qk_s2, qk_s3, qk_s4;
	logic [31:0] load_s4, rd_s4, scaled, load_val, freq_s4;
	logic [31:0] angle_s5;
	rpe_pkg::side_t side_s5, cside;
	logic        wr_en;
	logic [AW-1:0] addr;
	logic [31:0] freq_mem [PAIRS];

	logic signed [rpe_pkg::CW-1:0] co, si;
	logic        op_q, valid_q, sat_q;
	logic [15:0] qe_q, qo_q, ke_q, ko_q;
	logic [31:0] freq_q;

	assign en       = !valid_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			use_scaling_q <= 1'b1;
		else if (cfg_we)
			use_scaling_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			side_s5.valid <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			side_s5 <= '{valid: v_s4, op: op_s4, freq: freq_s4,
				qe: qk_s4[15:0], qo: qk_s4[31:16], ke: qk_s4[47:32], ko: qk_s4[63:48]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= s_tuser;
			pair_s1 <= s_tdata[5:0];
			in_s1   <= 9'(s_tdata[5:0]) < 9'(PAIRS);
			base_s1 <= s_tdata[37:6];
			pos_s1  <= s_tdata[53:38] & POS_MASK;
			qk_s1   <= s_tdata[117:54];
			op_s2   <= op_s1;
			pair_s2 <= pair_s1;
			in_s2   <= in_s1;
			pos_s2  <= pos_s1;
			qk_s2   <= qk_s1;
			op_s3   <= op_s2;
			pair_s3 <= pair_s2;
			in_s3   <= in_s2;
			pos_s3  <= pos_s2;
			qk_s3   <= qk_s2;
			op_s4   <= op_s3;
			in_s4   <= in_s3;
			pos_s4  <= pos_s3;
			qk_s4   <= qk_s3;
			load_s4 <= load_val;
			angle_s5     <= 32'(48'(pos_s4) * 48'(freq_s4));
		end
	end

	logic [31:0] base_s2, base_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			base_s2 <= base_s1;
			base_s3 <= base_s2;
		end
	end

	rpe_scale u_scale (
		.clk      (clk),
		.en       (en),
		.freq_in  (base_s1),
		.freq_out (scaled)
	);

	assign load_val = use_scaling_q ? scaled : base_s3;
	assign wr_en    = en && v_s3 && (op_s3 == rpe_pkg::OP_LOAD) && in_s3;
	assign addr     = AW'(pair_s3);

	always_ff @(posedge clk) begin
		if (wr_en)
			freq_mem[addr] <= load_val;
		if (en)
			rd_s4 <= freq_mem[addr];
	end

	always_comb begin
		if (!in_s4)
			freq_s4 = '0;
		else if (op_s4 == rpe_pkg::OP_ROTATE)
			freq_s4 = rd_s4;
		else
			freq_s4 = load_s4;
	end

	rpe_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.angle    (angle_s5),
		.side_in  (side_s5),
		.co       (co),
		.si       (si),
		.side_out (cside)
	);

	rpe_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.co      (co),
		.si      (si),
		.side_in (cside),
		.valid_q (valid_q),
		.op_q    (op_q),
		.qe_q    (qe_q),
		.qo_q    (qo_q),
		.ke_q    (ke_q),
		.ko_q    (ko_q),
		.freq_q  (freq_q),
		.sat_q   (sat_q)
	);

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'b0, sat_q, freq_q, ko_q, ke_q, qo_q, qe_q};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !m_tready) |=> ($stable(v_s1) && $stable(v_s4) && $stable(freq_q)))
		else $error("pipeline moved during stall");

	a_sat_rotate: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && sat_q) |-> (op_q == rpe_pkg::OP_ROTATE))
		else $error("saturation flagged on load");

	a_wr_load: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (v_s3 && op_s3 == rpe_pkg::OP_LOAD && 9'(pair_s3) < 9'(PAIRS)))
		else $error("table write without in-range load");

endmodule

>>> tb/sv/rpe_checker.sv
`timescale 1ns / 1ps

module rpe_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [119:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	output int           fail_count,
	output int           pending
);

	logic [31:0]  freq_mem [64];
	logic         scale_on;
	logic [103:0] result_q [$];

	function automatic logic [31:0] band_scale(input logic [31:0] f);
		logic [63:0] num;
		logic [63:0] den;
		if (f > 32'd2097152)
			return f;
		if (f < 32'd524288)
			return 32'((64'(f) + 64'd4) >> 3);
		num = 64'(f) * (64'd7 * 64'(f) - 64'd2097152);
		den = 64'd3 << 22;
		return 32'((num + den / 2) / den);
	endfunction

	function automatic logic [15:0] round_sat(input logic signed [63:0] acc, inout logic clip);
		logic signed [63:0] r;
		r = (acc + (64'sd1 <<< 29)) >>> 30;
		if (r > 64'sd32767) begin
			r = 64'sd32767;
			clip = 1'b1;
		end
		if (r < -64'sd32768) begin
			r = -64'sd32768;
			clip = 1'b1;
		end
		return r[15:0];
	endfunction

	function automatic logic [103:0] rotate_pair(input logic [31:0] f, input logic [15:0] pos,
			input logic signed [15:0] qe, qo, ke, ko);
		logic [31:0]        ang;
		logic signed [63:0] x, y, z, dx, dy, co, si;
		logic               clip;
		logic [15:0]        oqe, oqo, oke, oko;
		ang = 32'(64'(pos) * 64'(f));
		x = 64'(rpe_pkg::CORDIC_GAIN_INV);
		y = 64'sd0;
		z = 64'(ang[29:0]);
		for (int i = 0; i < rpe_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - 64'(rpe_pkg::ATAN_TURNS[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + 64'(rpe_pkg::ATAN_TURNS[i]);
			end
		end
		case (ang[31:30])
			2'd0: begin co = x; si = y; end
			2'd1: begin co = -y; si = x; end
			2'd2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
		clip = 1'b0;
		oqe = round_sat(co * qe - si * qo, clip);
		oqo = round_sat(si * qe + co * qo, clip);
		oke = round_sat(co * ke - si * ko, clip);
		oko = round_sat(si * ke + co * ko, clip);
		return {clip, f, oko, oke, oqo, oqe};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [5:0]  idx;
		logic [31:0] f;
		logic [103:0] exp_r;
		if (!arst_n) begin
			scale_on <= 1'b1;
			fail_count = 0;
			result_q.delete();
			pending = 0;
		end else begin
			if (cfg_we)
				scale_on <= cfg_wdata;
			if (s_tvalid && s_tready) begin
				idx = s_tdata[5:0];
				if (s_tuser == rpe_pkg::OP_LOAD) begin
					f = scale_on ? band_scale(s_tdata[37:6]) : s_tdata[37:6];
					freq_mem[idx] = f;
					result_q.push_back({1'b0, f, 64'd0});
				end else begin
					result_q.push_back(rotate_pair(freq_mem[idx], s_tdata[53:38],
						s_tdata[69:54], s_tdata[85:70], s_tdata[101:86], s_tdata[117:102]));
				end
			end
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", m_tdata);
				end else begin
					exp_r = result_q.pop_front();
					if (m_tdata !== exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: qe %h/%h qo %h/%h ke %h/%h ko %h/%h f %h/%h sat %b/%b",
								exp_r[15:0], m_tdata[15:0], exp_r[31:16], m_tdata[31:16],
								exp_r[47:32], m_tdata[47:32], exp_r[63:48], m_tdata[63:48],
								exp_r[95:64], m_tdata[95:64], exp_r[96], m_tdata[96]);
					end
				end
			end
			pending = result_q.size();
		end
	end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [119:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	int           fail_count;
	int           pending;
	int           stall_pct;
	int           idle_cycles;
	bit           loaded [64];

	rotary_position_embedding_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	rpe_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_request(input logic op, input logic [5:0] idx, input logic [31:0] freq,
			input logic [15:0] pos, input logic [15:0] qe, qo, ke, ko);
		while ($urandom_range(99) < stall_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, ko, ke, qo, qe, pos, freq, idx};
		if (op == rpe_pkg::OP_LOAD)
			loaded[idx] = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic rand_freq(output logic [31:0] f);
		case ($urandom_range(4))
			0: f = $urandom;
			1: f = $urandom_range(32'h3FFFFF);
			2: f = $urandom_range(32'h200000, 32'h80000);
			3: f = $urandom_range(65535);
			default: f = $urandom_range(32'h7FFFFF);
		endcase
	endtask

	task automatic rand_sample(output logic [15:0] v);
		case ($urandom_range(3))
			0: v = 16'($urandom);
			1: v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: v = 16'($signed($urandom_range(8192)) - 4096);
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_scaling(input logic val);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [5:0]  idx;
		logic [31:0] f;
		logic [15:0] qe, qo, ke, ko;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = rpe_pkg::OP_LOAD;
		m_tready    = 1'b0;
		stall_pct   = 29;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// scaling bands at reset setting: boundaries and extremes
		send_request(rpe_pkg::OP_LOAD, 6'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(rpe_pkg::OP_LOAD, 6'd1, 32'h7FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(rpe_pkg::OP_LOAD, 6'd2, 32'h80000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(rpe_pkg::OP_LOAD, 6'd3, 32'h150000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(rpe_pkg::OP_LOAD, 6'd4, 32'h200000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(rpe_pkg::OP_LOAD, 6'd5, 32'h200001, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(rpe_pkg::OP_LOAD, 6'd63, 32'hFFFFFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(rpe_pkg::OP_ROTATE, 6'd0, 32'd0, 16'hFFFF,
			16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		send_request(rpe_pkg::OP_ROTATE, 6'd63, 32'd0, 16'hFFFF,
			16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
		send_request(rpe_pkg::OP_ROTATE, 6'd63, 32'd0, 16'd1,
			16'h1000, 16'h0000, 16'h0000, 16'h1000);
		send_request(rpe_pkg::OP_ROTATE, 6'd5, 32'd0, 16'd0,
			16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		send_request(rpe_pkg::OP_ROTATE, 6'd4, 32'd0, 16'd1234,
			16'h1000, 16'hF000, 16'h0800, 16'h0000);
		drain();
		set_scaling(1'b0);
		// quadrant angles with scaling off
		send_request(rpe_pkg::OP_LOAD, 6'd10, 32'h40000000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(rpe_pkg::OP_LOAD, 6'd11, 32'h80000000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(rpe_pkg::OP_LOAD, 6'd12, 32'hC0000000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(rpe_pkg::OP_LOAD, 6'd13, 32'h7FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		for (int i = 10; i < 14; i++)
			send_request(rpe_pkg::OP_ROTATE, 6'(i), 32'd0, 16'd1,
				16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001);
		send_request(rpe_pkg::OP_ROTATE, 6'd13, 32'd0, 16'hFFFF,
			16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			set_scaling(phase[0]);
			stall_pct = (phase == 2) ? 0 : 29;
			for (int n = 0; n < 270; n++) begin
				idx = 6'($urandom_range(63));
				rand_freq(f);
				rand_sample(qe);
				rand_sample(qo);
				rand_sample(ke);
				rand_sample(ko);
				if (!loaded[idx] || $urandom_range(3) == 0)
					send_request(rpe_pkg::OP_LOAD, idx, f, 16'($urandom), qe, qo, ke, ko);
				else
					send_request(rpe_pkg::OP_ROTATE, idx, $urandom, 16'($urandom),
						qe, qo, ke, ko);
			end
			drain();
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> files.f
hdl/rpe_pkg.sv
hdl/rpe_scale.sv
hdl/rpe_cordic.sv
hdl/rpe_rotate.sv
hdl/rotary_position_embedding_core.sv
tb/sv/rpe_checker.sv
tb/sv/tb.sv
